### hw/rtl/lasq_pkg.sv
// shared constants, codes and types of the linear array queue with search
package lasq_pkg;

   localparam int DEPTH = 64;
   localparam int DATA_W = 32;
   localparam int OP_W = 2;
   localparam int STATUS_W = 3;
   localparam int POS_W = 7;
   // fill_end and count must hold DEPTH itself
   localparam int SLOT_W = $clog2(DEPTH + 1);

   localparam int GROUP_SIZE = 8;
   localparam int GROUP_OFF_W = $clog2(GROUP_SIZE);
   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_DEPTH = NUM_GROUPS * GROUP_SIZE;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_SEARCH  = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_OVERFLOW  = 3'd1,
      STATUS_UNDERFLOW = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic active;
   } cell_ctl_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] position;
   } find_res_type;

endpackage

### hw/rtl/lasq_req_if.sv
// request channel: operation, item value and search key
interface lasq_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [lasq_pkg::OP_W-1:0]              operation;
   logic signed [lasq_pkg::DATA_W-1:0]     item_value;
   logic signed [lasq_pkg::DATA_W-1:0]     search_key;

   modport source (output valid, output operation, output item_value,
                   output search_key, input ready);
   modport sink (input valid, input operation, input item_value,
                 input search_key, output ready);
endinterface

### hw/rtl/lasq_rsp_if.sv
// response channel: status, removed value and found position
interface lasq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [lasq_pkg::STATUS_W-1:0]          status;
   logic signed [lasq_pkg::DATA_W-1:0]     removed_value;
   logic [lasq_pkg::POS_W-1:0]             found_position;

   modport source (output valid, output status, output removed_value,
                   output found_position, input ready);
   modport sink (input valid, input status, input removed_value,
                 input found_position, output ready);
endinterface

### hw/rtl/lasq_cell.sv
// one queue cell: holds an entry, shifts toward the head, compares with the key
module lasq_cell (
   input  logic                                clock,
   input  lasq_pkg::cell_ctl_type              ctl,
   input  logic signed [lasq_pkg::DATA_W-1:0]  write_value,
   input  logic signed [lasq_pkg::DATA_W-1:0]  next_value,
   input  logic signed [lasq_pkg::DATA_W-1:0]  key,
   output logic signed [lasq_pkg::DATA_W-1:0]  value,
   output logic                                match
);

   logic signed [lasq_pkg::DATA_W-1:0] value_ff;
   logic signed [lasq_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) begin
         value_in = write_value;
      end else if (ctl.shift) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = ctl.active && (value_ff == key);

endmodule

### hw/rtl/lasq_find.sv
// first-match finder: match register, per-group encode, then group select
module lasq_find (
   input  logic                          clock,
   input  logic                          start,
   input  logic [lasq_pkg::DEPTH-1:0]    match,
   output lasq_pkg::find_res_type        result
);

   logic [lasq_pkg::DEPTH-1:0]           match_ff;
   logic [lasq_pkg::DEPTH-1:0]           match_in;
   logic [lasq_pkg::PAD_DEPTH-1:0]       padded;
   logic [lasq_pkg::NUM_GROUPS-1:0]      grp_hit_ff;
   logic [lasq_pkg::NUM_GROUPS-1:0]      grp_hit_in;
   logic [lasq_pkg::GROUP_OFF_W-1:0]     grp_off_ff [lasq_pkg::NUM_GROUPS];
   logic [lasq_pkg::GROUP_OFF_W-1:0]     grp_off_in [lasq_pkg::NUM_GROUPS];

   assign match_in = start ? match : match_ff;

   always_comb begin
      padded = '0;
      padded[lasq_pkg::DEPTH-1:0] = match_ff;
      for (int g = 0; g < lasq_pkg::NUM_GROUPS; g++) begin
         grp_hit_in[g] = 1'b0;
         grp_off_in[g] = '0;
         // scan from the top so the lowest set bit wins
         for (int j = lasq_pkg::GROUP_SIZE - 1; j >= 0; j--) begin
            if (padded[g*lasq_pkg::GROUP_SIZE + j]) begin
               grp_hit_in[g] = 1'b1;
               grp_off_in[g] = lasq_pkg::GROUP_OFF_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      match_ff   <= match_in;
      grp_hit_ff <= grp_hit_in;
      grp_off_ff <= grp_off_in;
   end

   always_comb begin
      result.hit = 1'b0;
      result.position = '0;
      for (int g = lasq_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_hit_ff[g]) begin
            result.hit = 1'b1;
            result.position = lasq_pkg::POS_W'(g * lasq_pkg::GROUP_SIZE)
                            + lasq_pkg::POS_W'(grp_off_ff[g])
                            + lasq_pkg::POS_W'(1);
         end
      end
   end

endmodule

### hw/rtl/linear_array_queue_with_search_core.sv
// linear array queue with search: row of entry cells, first-match finder, control
// enqueue, dequeue, empty search and unknown codes: result in the cycle after the
//    transfer; a new request can transfer every cycle unless rsp_bus stalls
// search on a non-empty queue: result passes the match register, per-group encode
//    register and group select; no request is taken meanwhile
// reset clears the fill count, entry count, control state and response valid;
//    entry contents stay undefined until written
module linear_array_queue_with_search_core (
   input  logic                clock,
   input  logic                reset,
   lasq_req_if.sink            req_bus,
   lasq_rsp_if.source          rsp_bus
);

   lasq_pkg::state_type                  state_ff;
   lasq_pkg::state_type                  state_in;
   logic [lasq_pkg::SLOT_W-1:0]          fill_end_ff;
   logic [lasq_pkg::SLOT_W-1:0]          fill_end_in;
   logic [lasq_pkg::SLOT_W-1:0]          count_ff;
   logic [lasq_pkg::SLOT_W-1:0]          count_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   lasq_pkg::status_type                 status_ff;
   lasq_pkg::status_type                 status_in;
   logic signed [lasq_pkg::DATA_W-1:0]   removed_ff;
   logic signed [lasq_pkg::DATA_W-1:0]   removed_in;
   logic [lasq_pkg::POS_W-1:0]           pos_ff;
   logic [lasq_pkg::POS_W-1:0]           pos_in;

   logic                                 accept;
   logic                                 rsp_free;
   logic                                 req_ready;
   logic                                 report_load;
   logic                                 rsp_load;
   logic                                 push;
   logic                                 pop;
   logic                                 start;
   lasq_pkg::op_type                     op;

   lasq_pkg::cell_ctl_type               cell_ctl [lasq_pkg::DEPTH];
   logic signed [lasq_pkg::DATA_W-1:0]   cell_value [lasq_pkg::DEPTH];
   logic [lasq_pkg::DEPTH-1:0]           match;
   lasq_pkg::find_res_type               find_res;

   assign op       = lasq_pkg::op_type'(req_bus.operation);
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept   = req_bus.valid && req_ready;

   // fsm outputs
   always_comb begin
      req_ready   = 1'b0;
      report_load = 1'b0;
      unique case (state_ff)
         lasq_pkg::ST_IDLE:   req_ready = rsp_free;
         lasq_pkg::ST_SCAN:   req_ready = 1'b0;
         lasq_pkg::ST_REPORT: report_load = rsp_free;
         default:             req_ready = 1'b0;
      endcase
   end

   // fsm next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lasq_pkg::ST_IDLE: begin
            if (accept && op == lasq_pkg::OP_SEARCH && count_ff != '0) begin
               state_in = lasq_pkg::ST_SCAN;
            end
         end
         lasq_pkg::ST_SCAN: state_in = lasq_pkg::ST_REPORT;
         lasq_pkg::ST_REPORT: begin
            if (rsp_free) begin
               state_in = lasq_pkg::ST_IDLE;
            end
         end
         default: state_in = lasq_pkg::ST_IDLE;
      endcase
   end

   // request decode and response build
   always_comb begin
      fill_end_in = fill_end_ff;
      count_in    = count_ff;
      status_in   = lasq_pkg::STATUS_OK;
      removed_in  = '0;
      pos_in      = '0;
      rsp_load    = 1'b0;
      push        = 1'b0;
      pop         = 1'b0;
      start       = 1'b0;
      if (accept) begin
         unique case (op)
            lasq_pkg::OP_ENQUEUE: begin
               rsp_load = 1'b1;
               if (fill_end_ff == lasq_pkg::SLOT_W'(lasq_pkg::DEPTH)) begin
                  status_in = lasq_pkg::STATUS_OVERFLOW;
               end else begin
                  push        = 1'b1;
                  fill_end_in = fill_end_ff + lasq_pkg::SLOT_W'(1);
                  count_in    = count_ff + lasq_pkg::SLOT_W'(1);
               end
            end
            lasq_pkg::OP_DEQUEUE: begin
               rsp_load = 1'b1;
               if (count_ff == '0) begin
                  status_in = lasq_pkg::STATUS_UNDERFLOW;
               end else begin
                  pop        = 1'b1;
                  removed_in = cell_value[0];
                  // last entry out: the queue starts over at slot zero
                  if (count_ff == lasq_pkg::SLOT_W'(1)) begin
                     count_in    = '0;
                     fill_end_in = '0;
                  end else begin
                     count_in = count_ff - lasq_pkg::SLOT_W'(1);
                  end
               end
            end
            lasq_pkg::OP_SEARCH: begin
               if (count_ff == '0) begin
                  rsp_load  = 1'b1;
                  status_in = lasq_pkg::STATUS_EMPTY;
               end else begin
                  start = 1'b1;
               end
            end
            default: rsp_load = 1'b1;
         endcase
      end else if (report_load) begin
         rsp_load = 1'b1;
         if (find_res.hit) begin
            pos_in = find_res.position;
         end else begin
            status_in = lasq_pkg::STATUS_NOT_FOUND;
         end
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lasq_pkg::ST_IDLE;
         fill_end_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_end_ff  <= fill_end_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
         pos_ff     <= pos_in;
      end
   end

   // cell row: cell 0 holds the head, entries move one cell down on dequeue
   for (genvar i = 0; i < lasq_pkg::DEPTH; i++) begin : g_cell
      logic signed [lasq_pkg::DATA_W-1:0] next_value;

      if (i == lasq_pkg::DEPTH - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_mid
         assign next_value = cell_value[i+1];
      end

      assign cell_ctl[i].shift  = pop;
      assign cell_ctl[i].load   = push && (count_ff == lasq_pkg::SLOT_W'(i));
      assign cell_ctl[i].active = lasq_pkg::SLOT_W'(i) < count_ff;

      lasq_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .write_value (req_bus.item_value),
         .next_value  (next_value),
         .key         (req_bus.search_key),
         .value       (cell_value[i]),
         .match       (match[i])
      );
   end

   lasq_find u_find (
      .clock  (clock),
      .start  (start),
      .match  (match),
      .result (find_res)
   );

   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.status         = status_ff;
   assign rsp_bus.removed_value  = removed_ff;
   assign rsp_bus.found_position = pos_ff;

   // live entries never run past the fill mark
   a_count_bounds: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fill_end_ff
      && fill_end_ff <= lasq_pkg::SLOT_W'(lasq_pkg::DEPTH))
      else $error("entry count or fill mark out of range");

   // a successful dequeue drops the count by one; the last one also clears the fill mark
   a_dequeue_count: assert property (@(posedge clock) disable iff (reset)
      pop |=> (count_ff == $past(count_ff) - lasq_pkg::SLOT_W'(1))
              && (count_ff != '0 || fill_end_ff == '0))
      else $error("dequeue left a wrong entry count");

   // a reported match lies among the live entries
   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lasq_pkg::ST_REPORT && find_res.hit)
      |-> (find_res.position != '0
           && lasq_pkg::SLOT_W'(find_res.position) <= count_ff))
      else $error("search match beyond the live entries");

   // a search in progress keeps the queue contents unchanged
   a_scan_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lasq_pkg::ST_SCAN) |=> $stable(count_ff) && $stable(fill_end_ff))
      else $error("queue changed during a search");

endmodule
